// File: sv/mroe_pkg.sv
`timescale 1ns / 1ps

package mroe_pkg;

  // Default matrix bounds
  localparam int unsigned MAX_ROWS_DEF = 8;
  localparam int unsigned MAX_COLS_DEF = 8;

  // Field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_SWAP   = 3'd2,
    OP_SCALE  = 3'd3,
    OP_ADDMUL = 3'd4
  } mroe_op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_BADOP = 2'd2
  } mroe_status_e;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;
  localparam logic [CNT_W-1:0]     ROW_COUNT_RST = 4'd8;
  localparam logic [CNT_W-1:0]     COL_COUNT_RST = 4'd8;

  // Memory write data source
  typedef enum logic [2:0] {
    WSEL_VALUE,
    WSEL_PROD,
    WSEL_SUM,
    WSEL_RDATA,
    WSEL_TEMP
  } mroe_wsel_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WR_EL,
    ST_RD_EL,
    ST_CAP_EL,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_WR_A,
    ST_WR_B,
    ST_RESP
  } mroe_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       mem_re;
    logic       mem_we;
    logic       sel_row_b;
    logic       sel_cnt;
    mroe_wsel_e wsel;
    logic       cap_ta;
    logic       cap_prod;
    logic       cap_rd;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       load_res;
  } mroe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    mroe_status_e    err;
    logic            cols_zero;
    logic            col_last;
    logic            res_free;
  } mroe_stat_t;

endpackage

// File: sv/mroe_ifs.sv
`timescale 1ns / 1ps

// Input item channel
interface mroe_item_if;
  logic                               valid;
  logic                               ready;
  logic [mroe_pkg::OP_W-1:0]          op;
  logic [mroe_pkg::ROW_W-1:0]         row_a;
  logic [mroe_pkg::ROW_W-1:0]         row_b;
  logic [mroe_pkg::COL_W-1:0]         col;
  logic signed [mroe_pkg::DATA_W-1:0] value;
  logic signed [mroe_pkg::DATA_W-1:0] factor;

  modport source (output valid, op, row_a, row_b, col, value, factor, input ready);
  modport sink   (input valid, op, row_a, row_b, col, value, factor, output ready);
endinterface

// Result channel
interface mroe_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [mroe_pkg::DATA_W-1:0]  read_value;
  logic [mroe_pkg::STATUS_W-1:0]       status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// Configuration write channel
interface mroe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mroe_pkg::CFG_IDX_W-1:0] index;
  logic [mroe_pkg::CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/mroe_ctrl.sv
`timescale 1ns / 1ps

module mroe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  mroe_pkg::mroe_stat_t stat_i,
  output mroe_pkg::mroe_cmd_t  cmd_o
);
  import mroe_pkg::*;

  mroe_state_e state_q, state_d;
  mroe_state_e loop_state;

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    item_ready_o = 1'b0;
    loop_state   = (stat_i.op == OP_ADDMUL) ? ST_RD_B : ST_RD_A;

    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.cnt_clr = 1'b1;
        priority if (stat_i.err != STATUS_DONE) begin
          state_d = ST_RESP;
        end else if (stat_i.op == OP_WRITE) begin
          state_d = ST_WR_EL;
        end else if (stat_i.op == OP_READ) begin
          state_d = ST_RD_EL;
        end else if (stat_i.cols_zero) begin
          state_d = ST_RESP;
        end else begin
          state_d = loop_state;
        end
      end
      ST_WR_EL: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WSEL_VALUE;
        state_d      = ST_RESP;
      end
      ST_RD_EL: begin
        cmd_o.mem_re = 1'b1;
        state_d      = ST_CAP_EL;
      end
      ST_CAP_EL: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RD_A: begin
        cmd_o.mem_re   = 1'b1;
        cmd_o.sel_cnt  = 1'b1;
        // rdata holds the source element here for add-multiple
        cmd_o.cap_prod = (stat_i.op == OP_ADDMUL);
        priority if (stat_i.op == OP_SCALE) begin
          state_d = ST_MUL;
        end else if (stat_i.op == OP_SWAP) begin
          state_d = ST_RD_B;
        end else begin
          state_d = ST_WR_A;
        end
      end
      ST_RD_B: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.sel_row_b = 1'b1;
        cmd_o.sel_cnt   = 1'b1;
        cmd_o.cap_ta    = 1'b1;
        state_d         = (stat_i.op == OP_SWAP) ? ST_WR_A : ST_RD_A;
      end
      ST_MUL: begin
        cmd_o.cap_prod = 1'b1;
        state_d        = ST_WR_A;
      end
      ST_WR_A: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.sel_cnt = 1'b1;
        priority if (stat_i.op == OP_SCALE) begin
          cmd_o.wsel = WSEL_PROD;
        end else if (stat_i.op == OP_SWAP) begin
          cmd_o.wsel = WSEL_RDATA;
        end else begin
          cmd_o.wsel = WSEL_SUM;
        end
        priority if (stat_i.op == OP_SWAP) begin
          state_d = ST_WR_B;
        end else if (stat_i.col_last) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = loop_state;
        end
      end
      ST_WR_B: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.sel_row_b = 1'b1;
        cmd_o.sel_cnt   = 1'b1;
        cmd_o.wsel      = WSEL_TEMP;
        if (stat_i.col_last) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = loop_state;
        end
      end
      ST_RESP: begin
        if (stat_i.res_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/mroe_datapath.sv
`timescale 1ns / 1ps

module mroe_datapath #(
  parameter int unsigned MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = mroe_pkg::MAX_COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mroe_pkg::mroe_cmd_t          cmd_i,
  output mroe_pkg::mroe_stat_t         stat_o,
  input  logic [mroe_pkg::OP_W-1:0]    op_i,
  input  logic [mroe_pkg::ROW_W-1:0]   row_a_i,
  input  logic [mroe_pkg::ROW_W-1:0]   row_b_i,
  input  logic [mroe_pkg::COL_W-1:0]   col_i,
  input  logic [mroe_pkg::DATA_W-1:0]  value_i,
  input  logic [mroe_pkg::DATA_W-1:0]  factor_i,
  mroe_cfg_if.sink                     cfg_i,
  mroe_res_if.source                   res_o
);
  import mroe_pkg::*;

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [CNT_W-1:0]    row_count_q, col_count_q;
  logic [OP_W-1:0]     op_q;
  logic [ROW_W-1:0]    ra_q, rb_q;
  logic [COL_W-1:0]    col_q;
  logic [DATA_W-1:0]   value_q, factor_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W:0]      cnt_nx;
  logic [CNT_W-1:0]    eff_cols;
  logic                ra_ok, rb_ok, col_ok;
  mroe_status_e        err;
  logic [ROW_W-1:0]    row_sel;
  logic [CNT_W-1:0]    col_sel;
  logic [AW-1:0]       addr;
  logic [DATA_W-1:0]   wdata;
  logic [DATA_W-1:0]   mem_q [Depth];
  logic [DATA_W-1:0]   rdata_q, temp_q, prod_q, rd_q;
  logic                res_valid_q;
  logic [DATA_W-1:0]   res_value_q;
  mroe_status_e        res_status_q;

  // Configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_ROW_COUNT) begin
        row_count_q <= cfg_i.data;
      end else begin
        col_count_q <= cfg_i.data;
      end
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= op_i;
      ra_q     <= row_a_i;
      rb_q     <= row_b_i;
      col_q    <= col_i;
      value_q  <= value_i;
      factor_q <= factor_i;
    end
  end

  // Range checks against the configured and physical size
  assign eff_cols = (32'(col_count_q) < MAX_COLS) ? col_count_q : CNT_W'(MAX_COLS);
  assign ra_ok    = (CNT_W'(ra_q) < row_count_q) && (32'(ra_q) < MAX_ROWS);
  assign rb_ok    = (CNT_W'(rb_q) < row_count_q) && (32'(rb_q) < MAX_ROWS);
  assign col_ok   = (CNT_W'(col_q) < col_count_q) && (32'(col_q) < MAX_COLS);

  always_comb begin
    unique case (op_q)
      OP_WRITE, OP_READ: err = (ra_ok && col_ok) ? STATUS_DONE : STATUS_RANGE;
      OP_SCALE:          err = ra_ok ? STATUS_DONE : STATUS_RANGE;
      OP_SWAP, OP_ADDMUL: err = (ra_ok && rb_ok) ? STATUS_DONE : STATUS_RANGE;
      default:           err = STATUS_BADOP;
    endcase
  end

  // Column counter for row operations
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_nx[CNT_W-1:0];
    end
  end

  assign cnt_nx = {1'b0, cnt_q} + (CNT_W + 1)'(1);

  // Element address: row times row pitch plus column
  assign row_sel = cmd_i.sel_row_b ? rb_q : ra_q;
  assign col_sel = cmd_i.sel_cnt ? cnt_q : CNT_W'(col_q);
  assign addr    = AW'(32'(row_sel) * MAX_COLS + 32'(col_sel));

  // Write data select
  always_comb begin
    unique case (cmd_i.wsel)
      WSEL_VALUE: wdata = value_q;
      WSEL_PROD:  wdata = prod_q;
      WSEL_SUM:   wdata = rdata_q + prod_q;
      WSEL_RDATA: wdata = rdata_q;
      WSEL_TEMP:  wdata = temp_q;
      default:    wdata = value_q;
    endcase
  end

  // Single-port matrix memory with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Operand holding and product register
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_ta) begin
      temp_q <= rdata_q;
    end
    if (cmd_i.cap_prod) begin
      prod_q <= rdata_q * factor_q;
    end
    if (cmd_i.cap_rd) begin
      rd_q <= rdata_q;
    end
  end

  // Result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_value_q  <= (op_q == OP_READ && err == STATUS_DONE) ? rd_q : '0;
      res_status_q <= err;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.read_value = res_value_q;
  assign res_o.status     = res_status_q;

  // Status to the controller
  assign stat_o.op        = op_q;
  assign stat_o.err       = err;
  assign stat_o.cols_zero = (eff_cols == '0);
  assign stat_o.col_last  = (cnt_nx == {1'b0, eff_cols});
  assign stat_o.res_free  = !res_valid_q || res_o.ready;

endmodule

// File: sv/matrix_row_operation_engine.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake      | Payload
// item_i   | in        | valid / ready  | op, row_a, row_b, col, value, factor
// res_o    | out       | valid / ready  | read_value, status
// cfg_i    | in        | valid / ready  | index, data (row_count, col_count)
//
// Row operations walk the effective columns through the single-port matrix memory:
// scale reads, multiplies and writes back each element of row A; add-multiple reads
// the row B element, then the row A element, and writes their combination to row A;
// swap reads both elements and writes each into the other row.
// Reset clears the sequencer, the result register and the configuration (8 by 8);
// the matrix memory itself is not cleared.
// A new item is taken while a finished result still waits in the output register;
// the next result waits only if that register is still full.

module matrix_row_operation_engine #(
  parameter int unsigned MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = mroe_pkg::MAX_COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mroe_item_if.sink   item_i,
  mroe_res_if.source  res_o,
  mroe_cfg_if.sink    cfg_i
);
  import mroe_pkg::*;

  mroe_cmd_t  cmd;
  mroe_stat_t stat;
  logic       item_ready;

  assign item_i.ready = item_ready;

  // Sequencer
  mroe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // Matrix memory and arithmetic
  mroe_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .op_i     (item_i.op),
    .row_a_i  (item_i.row_a),
    .row_b_i  (item_i.row_b),
    .col_i    (item_i.col),
    .value_i  (item_i.value),
    .factor_i (item_i.factor),
    .cfg_i    (cfg_i),
    .res_o    (res_o)
  );

endmodule

// File: sv/mroe_checker.sv
`timescale 1ns / 1ps

module mroe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          item_valid_i,
  input logic                          item_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [mroe_pkg::DATA_W-1:0]   res_read_value_i,
  input logic [mroe_pkg::STATUS_W-1:0] res_status_i
);
  import mroe_pkg::*;

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_read_value_i) && $stable(res_status_i))
    else $error("result payload changed while stalled");

  // One item at a time: no item taken in the cycle after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i |=> !item_ready_i)
    else $error("item accepted back to back");

  // Failed items return a zero read value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i != STATUS_DONE |-> res_read_value_i == '0)
    else $error("nonzero read value on error status");

endmodule

bind matrix_row_operation_engine mroe_checker u_mroe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .item_valid_i     (item_i.valid),
  .item_ready_i     (item_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_read_value_i (res_o.read_value),
  .res_status_i     (res_o.status)
);

// File: verif/matrix_row_operation_engine_tb.sv
`timescale 1ns / 1ps

module matrix_row_operation_engine_tb;
  import mroe_pkg::*;

  localparam int unsigned MAX_ROWS      = MAX_ROWS_DEF;
  localparam int unsigned MAX_COLS      = MAX_COLS_DEF;
  localparam int unsigned PHASE_COUNT   = 13;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PRINT_LIMIT   = 40;

  // Opcodes the block does not define
  localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row_a;
    logic [ROW_W-1:0]  row_b;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] factor;
  } matrix_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    mroe_status_e      status;
  } matrix_result_t;

  typedef struct {
    bit             is_counts;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    matrix_item_t   item;
    bit             typed;
    matrix_result_t want;
  } plan_step_t;

  logic clk;
  logic rst_n;

  mroe_item_if item_bus ();
  mroe_res_if  res_bus ();
  mroe_cfg_if  cfg_bus ();

  matrix_row_operation_engine dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .item_i (item_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Mirror of the matrix and the count registers
  logic [DATA_W-1:0] mirror_cells [MAX_ROWS*MAX_COLS];
  logic [CNT_W-1:0]  mirror_rows;
  logic [CNT_W-1:0]  mirror_cols;

  matrix_result_t pending_results [$];
  plan_step_t     directed_plan [$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned stall_cycles   = 0;
  int          tx_burst       = 0;
  int          rx_burst       = 0;

  // Generate clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold reset at start, then release it
  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int unsigned live_count(logic [CNT_W-1:0] cnt, int unsigned limit);
    return (cnt > limit) ? limit : cnt;
  endfunction

  // Apply one item to the mirror and return the result it gives
  function automatic matrix_result_t apply_row_op(matrix_item_t it);
    int unsigned rows;
    int unsigned cols;
    int unsigned base_a;
    int unsigned base_b;
    int unsigned i;
    logic [DATA_W-1:0] held;
    matrix_result_t r;
    rows = live_count(mirror_rows, MAX_ROWS);
    cols = live_count(mirror_cols, MAX_COLS);
    base_a = it.row_a * MAX_COLS;
    base_b = it.row_b * MAX_COLS;
    r.read_value = '0;
    r.status = STATUS_DONE;
    if (it.op > OP_ADDMUL) begin
      r.status = STATUS_BADOP;
    end else if (it.op == OP_WRITE || it.op == OP_READ) begin
      if (it.row_a >= rows || it.col >= cols) begin
        r.status = STATUS_RANGE;
      end else if (it.op == OP_WRITE) begin
        mirror_cells[base_a + it.col] = it.value;
      end else begin
        r.read_value = mirror_cells[base_a + it.col];
      end
    end else if (it.op == OP_SCALE) begin
      if (it.row_a >= rows) begin
        r.status = STATUS_RANGE;
      end else begin
        for (i = 0; i < cols; i++)
          mirror_cells[base_a + i] = mirror_cells[base_a + i] * it.factor;
      end
    end else if (it.row_a >= rows || it.row_b >= rows) begin
      r.status = STATUS_RANGE;
    end else if (it.op == OP_SWAP) begin
      for (i = 0; i < cols; i++) begin
        held = mirror_cells[base_a + i];
        mirror_cells[base_a + i] = mirror_cells[base_b + i];
        mirror_cells[base_b + i] = held;
      end
    end else begin
      for (i = 0; i < cols; i++)
        mirror_cells[base_a + i] = mirror_cells[base_a + i]
                                   + it.factor * mirror_cells[base_b + i];
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and runs with none
  function automatic int pick_gap(inout int burst_left);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (p < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_ONES;
      default: return '0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return pick_extreme();
    if (p < 50) return DATA_W'(int'($urandom_range(0, 200)) - 100);
    return $urandom;
  endfunction

  function automatic logic [DATA_W-1:0] pick_factor();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return DATA_W'(int'($urandom_range(0, 6)) - 3);
    if (p < 75) return pick_extreme();
    return $urandom;
  endfunction

  // Mostly in-range operations for the current counts, the rest raw noise
  function automatic matrix_item_t random_item();
    int unsigned rows;
    int unsigned cols;
    int unsigned p;
    matrix_item_t it;
    rows = live_count(mirror_rows, MAX_ROWS);
    cols = live_count(mirror_cols, MAX_COLS);
    it.value  = pick_value();
    it.factor = pick_factor();
    if ($urandom_range(0, 99) < 12 || rows == 0 || cols == 0) begin
      it.op    = OP_W'($urandom_range(0, 7));
      it.row_a = ROW_W'($urandom_range(0, 7));
      it.row_b = ROW_W'($urandom_range(0, 7));
      it.col   = COL_W'($urandom_range(0, 7));
    end else begin
      p = $urandom_range(0, 99);
      if (p < 25) it.op = OP_WRITE;
      else if (p < 55) it.op = OP_READ;
      else if (p < 70) it.op = OP_SWAP;
      else if (p < 85) it.op = OP_SCALE;
      else it.op = OP_ADDMUL;
      it.row_a = ROW_W'($urandom_range(0, rows - 1));
      it.row_b = ROW_W'($urandom_range(0, rows - 1));
      it.col   = COL_W'($urandom_range(0, cols - 1));
    end
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one item, record its expected result once accepted
  task automatic send_item(matrix_item_t it, bit typed, matrix_result_t want);
    matrix_result_t predicted;
    int gap;
    item_bus.valid  <= 1'b1;
    item_bus.op     <= it.op;
    item_bus.row_a  <= it.row_a;
    item_bus.row_b  <= it.row_b;
    item_bus.col    <= it.col;
    item_bus.value  <= it.value;
    item_bus.factor <= it.factor;
    do @(posedge clk); while (!item_bus.ready);
    predicted = apply_row_op(it);
    pending_results.push_back(typed ? want : predicted);
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop the item valid and wait for every outstanding result
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write both count registers back to back
  task automatic program_counts(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_ROW_COUNT;
    cfg_bus.data  <= rows;
    do @(posedge clk); while (!cfg_bus.ready);
    mirror_rows = rows;
    cfg_bus.index <= CFG_COL_COUNT;
    cfg_bus.data  <= cols;
    do @(posedge clk); while (!cfg_bus.ready);
    mirror_cols = cols;
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic void plan_op(logic [OP_W-1:0] op, logic [ROW_W-1:0] ra,
                                  logic [ROW_W-1:0] rb, logic [COL_W-1:0] c,
                                  logic [DATA_W-1:0] value, logic [DATA_W-1:0] factor,
                                  bit typed, logic [DATA_W-1:0] rd, mroe_status_e st);
    plan_step_t s;
    s.is_counts = 1'b0;
    s.rows = '0;
    s.cols = '0;
    s.item = '{op: op, row_a: ra, row_b: rb, col: c, value: value, factor: factor};
    s.typed = typed;
    s.want = '{read_value: rd, status: st};
    directed_plan.push_back(s);
  endfunction

  function automatic void plan_counts(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    plan_step_t s;
    s.is_counts = 1'b1;
    s.rows = rows;
    s.cols = cols;
    s.item = '0;
    s.typed = 1'b0;
    s.want = '{read_value: '0, status: STATUS_DONE};
    directed_plan.push_back(s);
  endfunction

  // Directed stimulus; typed expectations only where obvious
  function automatic void build_plan();
    // extremes at the corners
    plan_op(OP_WRITE, 0, 0, 0, WORD_MAX, 0, 1, '0, STATUS_DONE);
    plan_op(OP_READ, 0, 0, 0, 0, 0, 1, WORD_MAX, STATUS_DONE);
    plan_op(OP_WRITE, 7, 0, 7, WORD_MIN, 0, 1, '0, STATUS_DONE);
    plan_op(OP_READ, 7, 0, 7, 0, 0, 1, WORD_MIN, STATUS_DONE);
    // unknown opcodes
    plan_op(OP_UNKNOWN_FIRST, 1, 2, 3, 5, 5, 1, '0, STATUS_BADOP);
    plan_op(OP_UNKNOWN_LAST, 7, 7, 7, WORD_ONES, WORD_ONES, 1, '0, STATUS_BADOP);
    // row operations, wrapping and same-row cases
    plan_op(OP_SCALE, 0, 0, 0, 0, 2, 0, '0, STATUS_DONE);
    plan_op(OP_SWAP, 0, 7, 0, 0, 0, 0, '0, STATUS_DONE);
    plan_op(OP_SWAP, 3, 3, 0, 0, 0, 0, '0, STATUS_DONE);
    plan_op(OP_ADDMUL, 4, 4, 0, 0, WORD_ONES, 0, '0, STATUS_DONE);
    plan_op(OP_ADDMUL, 2, 7, 0, 0, WORD_MIN, 0, '0, STATUS_DONE);
    plan_op(OP_READ, 7, 0, 0, 0, 0, 0, '0, STATUS_DONE);
    // index range checks with a reduced matrix
    plan_counts(5, 3);
    plan_op(OP_WRITE, 5, 0, 0, 1, 0, 1, '0, STATUS_RANGE);
    plan_op(OP_READ, 0, 0, 3, 0, 0, 1, '0, STATUS_RANGE);
    plan_op(OP_SWAP, 4, 5, 0, 0, 0, 1, '0, STATUS_RANGE);
    plan_op(OP_SCALE, 4, 0, 0, 0, WORD_ONES, 0, '0, STATUS_DONE);
    plan_op(OP_ADDMUL, 5, 0, 0, 0, 1, 1, '0, STATUS_RANGE);
    // zero columns: element access fails, row ops touch nothing
    plan_counts(5, 0);
    plan_op(OP_SWAP, 1, 2, 0, 0, 0, 1, '0, STATUS_DONE);
    plan_op(OP_WRITE, 0, 0, 0, 9, 0, 1, '0, STATUS_RANGE);
    // zero rows
    plan_counts(0, 8);
    plan_op(OP_SCALE, 0, 0, 0, 0, 3, 1, '0, STATUS_RANGE);
    // counts past the array clamp to it
    plan_counts(15, 15);
    plan_op(OP_READ, 7, 0, 7, 0, 0, 0, '0, STATUS_DONE);
    plan_op(OP_ADDMUL, 7, 0, 0, 0, 3, 0, '0, STATUS_DONE);
  endfunction

  // Sender: fill, directed plan, then random phases
  initial begin
    matrix_item_t it;
    matrix_result_t none;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    none = '{read_value: '0, status: STATUS_DONE};
    item_bus.valid  <= 1'b0;
    item_bus.op     <= '0;
    item_bus.row_a  <= '0;
    item_bus.row_b  <= '0;
    item_bus.col    <= '0;
    item_bus.value  <= '0;
    item_bus.factor <= '0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= CFG_ROW_COUNT;
    cfg_bus.data    <= '0;
    mirror_rows = ROW_COUNT_RST;
    mirror_cols = COL_COUNT_RST;
    foreach (mirror_cells[i]) mirror_cells[i] = '0;
    build_plan();
    while (rst_n !== 1'b1) @(posedge clk);
    @(posedge clk);

    // Write every element so that no later access sees an unwritten one
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        it = '{op: OP_WRITE, row_a: ROW_W'(r), row_b: 0, col: COL_W'(c),
               value: pick_value(), factor: 0};
        send_item(it, 1'b0, none);
      end
    end

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_counts) begin
        wait_idle();
        program_counts(directed_plan[i].rows, directed_plan[i].cols);
      end else begin
        send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin rows = 8; cols = 8; end
        1: begin rows = 2; cols = 3; end
        2: begin rows = 1; cols = 1; end
        3: begin rows = 15; cols = 9; end
        4: begin rows = 0; cols = 5; end
        5: begin rows = 7; cols = 0; end
        6: begin rows = 4; cols = 8; end
        7: begin rows = 8; cols = 1; end
        default: begin
          rows = CNT_W'($urandom_range(1, 8));
          cols = CNT_W'($urandom_range(1, 8));
        end
      endcase
      wait_idle();
      program_counts(rows, cols);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = random_item();
        send_item(it, 1'b0, none);
      end
    end

    // Drain, then let the block settle before the verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Receiver: random ready, with one long hold-off to back the block up
  initial begin
    int gap;
    bit held_off;
    held_off = 1'b0;
    res_bus.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = pick_gap(rx_burst);
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    matrix_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result read_value %h status %0d",
                                  res_bus.read_value, res_bus.status));
      end else begin
        want = pending_results.pop_front();
        if (res_bus.read_value !== want.read_value)
          report_mismatch($sformatf("result %0d read_value got %h want %h",
                                    results_seen, res_bus.read_value, want.read_value));
        if (res_bus.status !== want.status)
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    results_seen, res_bus.status, want.status));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, stall_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// File: files.f
sv/mroe_pkg.sv
sv/mroe_ifs.sv
sv/mroe_ctrl.sv
sv/mroe_datapath.sv
sv/matrix_row_operation_engine.sv
sv/mroe_checker.sv
verif/matrix_row_operation_engine_tb.sv
